// ===== design/sba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_pkg
// shared widths, types and codes of the swept box collision block
// ----------------------------------------------------------------------------
package sba_pkg;

    localparam int COORD_BITS     = 24;
    localparam int SIZE_BITS      = COORD_BITS - 1;
    localparam int TIME_FRAC_BITS = 16;
    localparam int TIME_BITS      = TIME_FRAC_BITS + 2;  // output time, Q1.f
    localparam int TW             = TIME_FRAC_BITS + 3;  // internal time, -2..2
    localparam int QUOT_BITS      = TIME_FRAC_BITS + 2;  // quotient bits
    localparam int VEL_BITS       = COORD_BITS + 1;
    localparam int D2_BITS        = COORD_BITS + 2;
    localparam int SUM_BITS       = COORD_BITS;
    localparam int DEN_BITS       = COORD_BITS + 2;
    localparam int MAG_BITS       = COORD_BITS + 2;
    localparam int NUM_BITS       = COORD_BITS + 3;
    localparam int EDGE_BITS      = COORD_BITS + 3;
    localparam int PIPE_DEPTH     = QUOT_BITS + 4;

    typedef logic signed [TW-1:0] time_t;

    localparam time_t TIME_ONE = TW'(2 ** TIME_FRAC_BITS);
    localparam time_t TIME_LIM = TW'(2 ** (TIME_FRAC_BITS + 1));

    typedef enum logic [1:0] {
        SIDE_RIGHT = 2'd0,
        SIDE_UP    = 2'd1,
        SIDE_LEFT  = 2'd2,
        SIDE_DOWN  = 2'd3
    } side_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_center_x;
        logic signed [COORD_BITS-1:0] first_center_y;
        logic        [SIZE_BITS-1:0]  first_size_x;
        logic        [SIZE_BITS-1:0]  first_size_y;
        logic signed [COORD_BITS-1:0] second_center_x;
        logic signed [COORD_BITS-1:0] second_center_y;
        logic        [SIZE_BITS-1:0]  second_size_x;
        logic        [SIZE_BITS-1:0]  second_size_y;
        logic signed [COORD_BITS-1:0] first_vel_x;
        logic signed [COORD_BITS-1:0] first_vel_y;
        logic signed [COORD_BITS-1:0] second_vel_x;
        logic signed [COORD_BITS-1:0] second_vel_y;
    } box_req_t;

    // per axis flags that ride beside the dividers
    typedef struct packed {
        logic vz;       // zero relative velocity
        logic vneg;     // negative relative velocity
        logic overlap;  // static overlap
        logic p1lt;     // first center below second
        logic lo_ovf;
        logic lo_neg;
        logic hi_ovf;
        logic hi_neg;
    } axis_meta_t;

    typedef struct packed {
        axis_meta_t x;
        axis_meta_t y;
    } pair_meta_t;

    // divider launch data of one quotient
    typedef struct packed {
        logic [DEN_BITS-1:0] rem0;
        logic [1:0]          nbits;
    } div_launch_t;

    typedef struct packed {
        axis_meta_t          meta;
        logic [DEN_BITS-1:0] den;
        div_launch_t         lo;
        div_launch_t         hi;
    } front_axis_t;

    typedef struct packed {
        logic [QUOT_BITS-1:0] quot;
        logic                 rem_nz;
    } div_res_t;

endpackage

// ===== design/sba_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba request and result channels
// valid/ready channels carrying box pairs and collision results
// ----------------------------------------------------------------------------
interface sba_in_if;
    logic valid;
    logic ready;
    logic signed [sba_pkg::COORD_BITS-1:0] first_center_x;
    logic signed [sba_pkg::COORD_BITS-1:0] first_center_y;
    logic        [sba_pkg::SIZE_BITS-1:0]  first_size_x;
    logic        [sba_pkg::SIZE_BITS-1:0]  first_size_y;
    logic signed [sba_pkg::COORD_BITS-1:0] second_center_x;
    logic signed [sba_pkg::COORD_BITS-1:0] second_center_y;
    logic        [sba_pkg::SIZE_BITS-1:0]  second_size_x;
    logic        [sba_pkg::SIZE_BITS-1:0]  second_size_y;
    logic signed [sba_pkg::COORD_BITS-1:0] first_vel_x;
    logic signed [sba_pkg::COORD_BITS-1:0] first_vel_y;
    logic signed [sba_pkg::COORD_BITS-1:0] second_vel_x;
    logic signed [sba_pkg::COORD_BITS-1:0] second_vel_y;

    modport source (output valid, first_center_x, first_center_y, first_size_x,
                    first_size_y, second_center_x, second_center_y, second_size_x,
                    second_size_y, first_vel_x, first_vel_y, second_vel_x,
                    second_vel_y, input ready);
    modport sink (input valid, first_center_x, first_center_y, first_size_x,
                  first_size_y, second_center_x, second_center_y, second_size_x,
                  second_size_y, first_vel_x, first_vel_y, second_vel_x,
                  second_vel_y, output ready);
endinterface

interface sba_out_if;
    logic valid;
    logic ready;
    logic                                 hit;
    logic signed [sba_pkg::TIME_BITS-1:0] contact_time;
    logic        [1:0]                    side_code;

    modport source (output valid, hit, contact_time, side_code, input ready);
    modport sink (input valid, hit, contact_time, side_code, output ready);
endinterface

// ===== design/sba_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_front
// two register stages: relative motion and edges, then numerators and launch
// ----------------------------------------------------------------------------
module sba_front (
    input  logic              clk,
    input  logic              adv,
    input  sba_pkg::box_req_t req,
    output sba_pkg::front_axis_t x_out,
    output sba_pkg::front_axis_t y_out
);
    import sba_pkg::*;

    typedef struct packed {
        logic                       vz;
        logic                       vneg;
        logic                       overlap;
        logic                       p1lt;
        logic signed [D2_BITS-1:0]  d2;
        logic        [SUM_BITS-1:0] s;
        logic        [DEN_BITS-1:0] den;
    } s1_axis_t;

    logic signed [COORD_BITS-1:0] p1 [2];
    logic signed [COORD_BITS-1:0] p2 [2];
    logic signed [COORD_BITS-1:0] v1 [2];
    logic signed [COORD_BITS-1:0] v2 [2];
    logic        [SIZE_BITS-1:0]  s1 [2];
    logic        [SIZE_BITS-1:0]  s2 [2];
    s1_axis_t    s1_reg  [2];
    s1_axis_t    s1_next [2];
    front_axis_t s2_reg  [2];
    front_axis_t s2_next [2];

    assign p1[0] = req.first_center_x;
    assign p1[1] = req.first_center_y;
    assign p2[0] = req.second_center_x;
    assign p2[1] = req.second_center_y;
    assign v1[0] = req.first_vel_x;
    assign v1[1] = req.first_vel_y;
    assign v2[0] = req.second_vel_x;
    assign v2[1] = req.second_vel_y;
    assign s1[0] = req.first_size_x;
    assign s1[1] = req.first_size_y;
    assign s2[0] = req.second_size_x;
    assign s2[1] = req.second_size_y;

    function automatic div_launch_t launch(input logic [MAG_BITS-1:0] mag);
        div_launch_t l;
        l.rem0  = {2'b00, mag[MAG_BITS-1:2]};
        l.nbits = mag[1:0];
        return l;
    endfunction

    for (genvar a = 0; a < 2; a++) begin : g_axis
        logic signed [VEL_BITS-1:0]  vrel;
        logic        [VEL_BITS-1:0]  vabs;
        logic signed [VEL_BITS-1:0]  pdiff;
        logic signed [EDGE_BITS-1:0] p1w;
        logic signed [EDGE_BITS-1:0] p2w;
        logic signed [EDGE_BITS-1:0] s1w;
        logic signed [EDGE_BITS-1:0] s2w;
        logic signed [NUM_BITS-1:0]  num_lo;
        logic signed [NUM_BITS-1:0]  num_hi;
        logic        [MAG_BITS-1:0]  mag_lo;
        logic        [MAG_BITS-1:0]  mag_hi;
        logic        [NUM_BITS-1:0]  neg_lo;
        logic        [NUM_BITS-1:0]  neg_hi;

        always_comb
        begin
            vrel  = VEL_BITS'(v1[a]) - VEL_BITS'(v2[a]);
            vabs  = vrel[VEL_BITS-1] ? VEL_BITS'(-vrel) : vrel;
            pdiff = VEL_BITS'(p2[a]) - VEL_BITS'(p1[a]);
            p1w   = {p1[a][COORD_BITS-1], p1[a][COORD_BITS-1], p1[a], 1'b0};
            p2w   = {p2[a][COORD_BITS-1], p2[a][COORD_BITS-1], p2[a], 1'b0};
            s1w   = {4'b0000, s1[a]};
            s2w   = {4'b0000, s2[a]};
            s1_next[a].vz      = (vrel == '0);
            s1_next[a].vneg    = vrel[VEL_BITS-1];
            s1_next[a].overlap = (p1w + s1w > p2w - s2w) && (p1w - s1w < p2w + s2w);
            s1_next[a].p1lt    = (p1[a] < p2[a]);
            s1_next[a].d2      = {pdiff, 1'b0};
            s1_next[a].s       = {1'b0, s1[a]} + {1'b0, s2[a]};
            s1_next[a].den     = {vabs, 1'b0};
        end

        always_comb
        begin
            num_lo = NUM_BITS'(s1_reg[a].d2) - $signed({3'b000, s1_reg[a].s});
            num_hi = NUM_BITS'(s1_reg[a].d2) + $signed({3'b000, s1_reg[a].s});
            neg_lo = -num_lo;
            neg_hi = -num_hi;
            mag_lo = num_lo[NUM_BITS-1] ? neg_lo[MAG_BITS-1:0] : num_lo[MAG_BITS-1:0];
            mag_hi = num_hi[NUM_BITS-1] ? neg_hi[MAG_BITS-1:0] : num_hi[MAG_BITS-1:0];
            s2_next[a].meta.vz      = s1_reg[a].vz;
            s2_next[a].meta.vneg    = s1_reg[a].vneg;
            s2_next[a].meta.overlap = s1_reg[a].overlap;
            s2_next[a].meta.p1lt    = s1_reg[a].p1lt;
            // quotient reaches four or more: saturate
            s2_next[a].meta.lo_ovf  = {2'b00, mag_lo} >= {s1_reg[a].den, 2'b00};
            s2_next[a].meta.hi_ovf  = {2'b00, mag_hi} >= {s1_reg[a].den, 2'b00};
            s2_next[a].meta.lo_neg  = num_lo[NUM_BITS-1] ^ s1_reg[a].vneg;
            s2_next[a].meta.hi_neg  = num_hi[NUM_BITS-1] ^ s1_reg[a].vneg;
            s2_next[a].den          = s1_reg[a].den;
            s2_next[a].lo           = launch(mag_lo);
            s2_next[a].hi           = launch(mag_hi);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s1_reg[a] <= s1_next[a];
                s2_reg[a] <= s2_next[a];
            end
        end
    end

    assign x_out = s2_reg[0];
    assign y_out = s2_reg[1];

endmodule

// ===== design/sba_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module sba_div (
    input  logic                         clk,
    input  logic                         adv,
    input  logic [sba_pkg::DEN_BITS-1:0] den,
    input  sba_pkg::div_launch_t         launch,
    output sba_pkg::div_res_t            res
);
    import sba_pkg::*;

    logic [DEN_BITS-1:0]  rem_reg  [QUOT_BITS];
    logic [QUOT_BITS-1:0] quot_reg [QUOT_BITS];
    logic [DEN_BITS-1:0]  den_reg  [QUOT_BITS-1];
    logic [QUOT_BITS-1:0] xb_reg   [QUOT_BITS-1];

    for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
        localparam int BIT = QUOT_BITS - 1 - k;
        logic [DEN_BITS-1:0]  rin;
        logic [DEN_BITS-1:0]  din;
        logic [QUOT_BITS-1:0] qin;
        logic [QUOT_BITS-1:0] xin;
        logic [DEN_BITS:0]    cand;
        logic                 ge;
        logic [DEN_BITS-1:0]  rem_next;
        logic [QUOT_BITS-1:0] quot_next;

        if (k == 0) begin : g_first
            assign rin = launch.rem0;
            assign din = den;
            assign qin = '0;
            assign xin = {launch.nbits, {TIME_FRAC_BITS{1'b0}}};
        end else begin : g_rest
            assign rin = rem_reg[k-1];
            assign din = den_reg[k-1];
            assign qin = quot_reg[k-1];
            assign xin = xb_reg[k-1];
        end

        always_comb
        begin
            cand      = {rin, xin[QUOT_BITS-1]};
            ge        = cand >= {1'b0, din};
            rem_next  = ge ? DEN_BITS'(cand - {1'b0, din}) : cand[DEN_BITS-1:0];
            quot_next = qin;
            quot_next[BIT] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next;
                quot_reg[k] <= quot_next;
            end
        end

        if (k < QUOT_BITS - 1) begin : g_pass
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    den_reg[k] <= din;
                    xb_reg[k]  <= {xin[QUOT_BITS-2:0], 1'b0};
                end
            end
        end
    end

    assign res.quot   = quot_reg[QUOT_BITS-1];
    assign res.rem_nz = |rem_reg[QUOT_BITS-1];

endmodule

// ===== design/sba_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_decide
// rounds and orders the sweep times, then forms the hit result register
// ----------------------------------------------------------------------------
module sba_decide (
    input  logic               clk,
    input  logic               adv,
    input  sba_pkg::pair_meta_t meta,
    input  sba_pkg::div_res_t  x_lo,
    input  sba_pkg::div_res_t  x_hi,
    input  sba_pkg::div_res_t  y_lo,
    input  sba_pkg::div_res_t  y_hi,
    output logic                                 hit,
    output logic signed [sba_pkg::TIME_BITS-1:0] contact_time,
    output logic [1:0]                           side_code
);
    import sba_pkg::*;

    time_t xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    time_t xmin_next, xmax_next, ymin_next, ymax_next;
    logic  xlt_reg, ylt_reg;
    logic  hit_reg, hit_next;
    logic signed [TIME_BITS-1:0] time_reg, time_next;
    side_t side_reg, side_next;
    time_t t;

    // floor for positive quotients, ceiling of magnitude for negative ones
    function automatic time_t fin(input div_res_t r, input logic ovf, input logic neg);
        logic [TW-1:0] m;
        m = {1'b0, r.quot} + TW'(neg & r.rem_nz);
        if (ovf || m > TIME_LIM)
            m = TIME_LIM;
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic void order(input axis_meta_t am, input time_t lo, input time_t hi,
                                  output time_t tmin, output time_t tmax);
        if (am.vz)
        begin
            tmin = am.overlap ? time_t'(0) : -TIME_ONE;
            tmax = am.overlap ? TIME_ONE : -TIME_ONE;
        end
        else if (am.vneg)
        begin
            tmin = hi;
            tmax = lo;
        end
        else
        begin
            tmin = lo;
            tmax = hi;
        end
    endfunction

    always_comb
    begin
        order(meta.x, fin(x_lo, meta.x.lo_ovf, meta.x.lo_neg),
              fin(x_hi, meta.x.hi_ovf, meta.x.hi_neg), xmin_next, xmax_next);
        order(meta.y, fin(y_lo, meta.y.lo_ovf, meta.y.lo_neg),
              fin(y_hi, meta.y.hi_ovf, meta.y.hi_neg), ymin_next, ymax_next);
    end

    always_comb
    begin
        hit_next  = (xmin_reg <= TIME_ONE) && (xmax_reg >= 0) &&
                    (ymin_reg <= TIME_ONE) && (ymax_reg >= 0) &&
                    (xmin_reg <= ymax_reg) && (ymin_reg <= xmax_reg);
        t         = '0;
        side_next = SIDE_RIGHT;
        if (xmin_reg > ymin_reg)
        begin
            t         = xmin_reg;
            side_next = xlt_reg ? SIDE_LEFT : SIDE_RIGHT;
        end
        else
        begin
            t         = ymin_reg;
            side_next = ylt_reg ? SIDE_DOWN : SIDE_UP;
        end
        if (t > TIME_ONE)
            t = TIME_ONE;
        if (t < -TIME_ONE)
            t = -TIME_ONE;
        time_next = TIME_BITS'(t);
        if (!hit_next)
        begin
            time_next = '0;
            side_next = SIDE_RIGHT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xmin_reg <= xmin_next;
            xmax_reg <= xmax_next;
            ymin_reg <= ymin_next;
            ymax_reg <= ymax_next;
            xlt_reg  <= meta.x.p1lt;
            ylt_reg  <= meta.y.p1lt;
            hit_reg  <= hit_next;
            time_reg <= time_next;
            side_reg <= side_next;
        end
    end

    assign hit          = hit_reg;
    assign contact_time = time_reg;
    assign side_code    = side_reg;

endmodule

// ===== design/swept_box_collision_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_box_collision_top
// swept collision test of two axis-aligned boxes over one motion step
// ----------------------------------------------------------------------------
// Takes one box pair per clock while results are taken and returns exactly
// one result per request, in order, through two front stages, one stage per
// quotient bit in the 18-stage dividers, a time ordering stage and the result
// register. The four sweep divisions run in parallel pipelined dividers, so
// the sustained rate is one request per cycle. A stalled result holds the
// whole pipeline in place; in_req.ready follows the result register, which is
// free whenever it is empty or being taken. Times are Q1.16, floor-rounded,
// saturated to -1..1, and zero with side code 0 when there is no hit.
// ----------------------------------------------------------------------------
module swept_box_collision_top (
    input  logic        clk,
    input  logic        rst_n,
    sba_in_if.sink      in_req,
    sba_out_if.source   out_res
);
    import sba_pkg::*;

    box_req_t    req;
    front_axis_t fx, fy;
    pair_meta_t  meta_reg [QUOT_BITS];
    div_res_t    rx_lo, rx_hi, ry_lo, ry_hi;
    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;
    logic        adv;

    // the whole pipe moves unless a finished result is held back
    assign adv          = !vld_reg[PIPE_DEPTH-1] || out_res.ready;
    assign in_req.ready = adv;

    assign req.first_center_x  = in_req.first_center_x;
    assign req.first_center_y  = in_req.first_center_y;
    assign req.first_size_x    = in_req.first_size_x;
    assign req.first_size_y    = in_req.first_size_y;
    assign req.second_center_x = in_req.second_center_x;
    assign req.second_center_y = in_req.second_center_y;
    assign req.second_size_x   = in_req.second_size_x;
    assign req.second_size_y   = in_req.second_size_y;
    assign req.first_vel_x     = in_req.first_vel_x;
    assign req.first_vel_y     = in_req.first_vel_y;
    assign req.second_vel_x    = in_req.second_vel_x;
    assign req.second_vel_y    = in_req.second_vel_y;

    // relative motion, edges, numerators and divider launch values
    sba_front u_front (
        .clk   (clk),
        .adv   (adv),
        .req   (req),
        .x_out (fx),
        .y_out (fy)
    );

    // entry and exit quotients of both axes
    sba_div u_div_xlo (.clk(clk), .adv(adv), .den(fx.den), .launch(fx.lo), .res(rx_lo));
    sba_div u_div_xhi (.clk(clk), .adv(adv), .den(fx.den), .launch(fx.hi), .res(rx_hi));
    sba_div u_div_ylo (.clk(clk), .adv(adv), .den(fy.den), .launch(fy.lo), .res(ry_lo));
    sba_div u_div_yhi (.clk(clk), .adv(adv), .den(fy.den), .launch(fy.hi), .res(ry_hi));

    // flags ride beside the dividers, one register per quotient stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0].x <= fx.meta;
            meta_reg[0].y <= fy.meta;
            for (int k = 1; k < QUOT_BITS; k++)
                meta_reg[k] <= meta_reg[k-1];
        end
    end

    // rounding, interval test and the result register
    sba_decide u_decide (
        .clk          (clk),
        .adv          (adv),
        .meta         (meta_reg[QUOT_BITS-1]),
        .x_lo         (rx_lo),
        .x_hi         (rx_hi),
        .y_lo         (ry_lo),
        .y_hi         (ry_hi),
        .hit          (out_res.hit),
        .contact_time (out_res.contact_time),
        .side_code    (out_res.side_code)
    );

    // one valid bit per stage, last one is the result register
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], in_req.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    assign out_res.valid = vld_reg[PIPE_DEPTH-1];

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_res.valid && !out_res.hit |-> out_res.contact_time == 0 &&
        out_res.side_code == SIDE_RIGHT)
        else $error("miss result carries time or side");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_res.valid && out_res.hit |->
        out_res.contact_time <= TIME_BITS'(TIME_ONE) &&
        out_res.contact_time >= -TIME_BITS'(TIME_ONE))
        else $error("contact time outside one step");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_res.valid && !out_res.ready |-> !in_req.ready)
        else $error("request taken while result held");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_res.valid && !out_res.ready |=> out_res.valid &&
        $stable(out_res.contact_time) && $stable(out_res.side_code))
        else $error("held result changed");

endmodule

// ===== tb/sv/sba_contact_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_contact_checker
// watches both channels, predicts each contact result and compares in order
// ----------------------------------------------------------------------------
module sba_contact_checker (
    input  logic clk,
    input  logic rst_n,
    sba_in_if    in_mon,
    sba_out_if   out_mon,
    output int   pending,
    output int   errors
);
    import sba_pkg::*;

    localparam longint ONE = longint'(1) << TIME_FRAC_BITS;

    typedef struct {
        logic                        hit;
        logic signed [TIME_BITS-1:0] contact_time;
        logic [1:0]                  side_code;
    } contact_t;

    contact_t expected_contacts[$];

    // floor(num * 2^f / den), clamped to -2..2
    function automatic longint sweep_time(longint num, longint den);
        longint n, q, lim;
        n   = num * ONE;
        lim = 2 * ONE;
        if (den < 0)
        begin
            n   = -n;
            den = -den;
        end
        q = n / den;
        if ((n % den) != 0 && n < 0)
            q = q - 1;
        if (q > lim)
            q = lim;
        if (q < -lim)
            q = -lim;
        return q;
    endfunction

    task automatic axis_window(input longint p1, input longint s1, input longint p2,
                               input longint s2, input longint v,
                               output longint tmin, output longint tmax);
        longint d2, s, a, b;
        d2 = 2 * (p2 - p1);
        s  = s1 + s2;
        if (v != 0)
        begin
            a = sweep_time(d2 - s, 2 * v);
            b = sweep_time(d2 + s, 2 * v);
            tmin = (v < 0) ? b : a;
            tmax = (v < 0) ? a : b;
        end
        else if (2 * p1 + s1 > 2 * p2 - s2 && 2 * p1 - s1 < 2 * p2 + s2)
        begin
            tmin = 0;
            tmax = ONE;
        end
        else
        begin
            tmin = -ONE;
            tmax = -ONE;
        end
    endtask

    task automatic predict_contact(input box_req_t r, output contact_t c);
        longint p1x, p1y, p2x, p2y, xmin, xmax, ymin, ymax, t;
        side_t  side;
        p1x = longint'(r.first_center_x);
        p1y = longint'(r.first_center_y);
        p2x = longint'(r.second_center_x);
        p2y = longint'(r.second_center_y);
        axis_window(p1x, longint'(r.first_size_x), p2x, longint'(r.second_size_x),
                    longint'(r.first_vel_x) - longint'(r.second_vel_x), xmin, xmax);
        axis_window(p1y, longint'(r.first_size_y), p2y, longint'(r.second_size_y),
                    longint'(r.first_vel_y) - longint'(r.second_vel_y), ymin, ymax);
        c.hit          = 1'b0;
        c.contact_time = '0;
        c.side_code    = 2'(SIDE_RIGHT);
        if (xmin <= ONE && xmax >= 0 && ymin <= ONE && ymax >= 0 &&
            xmin <= ymax && ymin <= xmax)
        begin
            // a tie goes to the y face
            if (xmin > ymin)
            begin
                t    = xmin;
                side = (p1x < p2x) ? SIDE_LEFT : SIDE_RIGHT;
            end
            else
            begin
                t    = ymin;
                side = (p1y < p2y) ? SIDE_DOWN : SIDE_UP;
            end
            if (t > ONE)
                t = ONE;
            if (t < -ONE)
                t = -ONE;
            c.hit          = 1'b1;
            c.contact_time = t[TIME_BITS-1:0];
            c.side_code    = 2'(side);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t sba_contact_checker: %s", $realtime, what);
        errors = errors + 1;
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        box_req_t r;
        contact_t want;
        if (rst_n)
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_contacts.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want = expected_contacts.pop_front();
                    if (out_mon.hit !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b",
                                                  out_mon.hit, want.hit));
                    if (out_mon.contact_time !== want.contact_time)
                        report_mismatch($sformatf("contact_time %0d, want %0d",
                                                  out_mon.contact_time, want.contact_time));
                    if (out_mon.side_code !== want.side_code)
                        report_mismatch($sformatf("side_code %0d, want %0d",
                                                  out_mon.side_code, want.side_code));
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                r.first_center_x  = in_mon.first_center_x;
                r.first_center_y  = in_mon.first_center_y;
                r.first_size_x    = in_mon.first_size_x;
                r.first_size_y    = in_mon.first_size_y;
                r.second_center_x = in_mon.second_center_x;
                r.second_center_y = in_mon.second_center_y;
                r.second_size_x   = in_mon.second_size_x;
                r.second_size_y   = in_mon.second_size_y;
                r.first_vel_x     = in_mon.first_vel_x;
                r.first_vel_y     = in_mon.first_vel_y;
                r.second_vel_x    = in_mon.second_vel_x;
                r.second_vel_y    = in_mon.second_vel_y;
                predict_contact(r, want);
                expected_contacts.push_back(want);
            end
            pending = expected_contacts.size();
        end
    end

endmodule

// ===== tb/sv/tb_swept_box_collision_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swept_box_collision_top
// stimulus and verdict for the swept box collision block
// ----------------------------------------------------------------------------
// Sends a directed set of box pairs (field extremes, each struck face, static
// overlap and touching, tied entry times, already overlapping pairs), then
// about 1200 random pairs, mostly close-range pairs that can really collide,
// some fully random. Both channels idle in random bursts; the last part runs
// without idling. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_swept_box_collision_top;
    import sba_pkg::*;

    localparam int RANDOM_PAIRS = 1200;
    localparam int CALM_TAIL    = 200;
    localparam int STALL_LIMIT  = 5000;

    logic clk;
    logic rst_n;
    bit   calm;          // no idling on either side
    int   pending;
    int   errors;
    int   stall_left;
    int   idle_cycles;

    sba_in_if  in_req();
    sba_out_if out_res();

    swept_box_collision_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_req  (in_req),
        .out_res (out_res)
    );

    sba_contact_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_mon  (in_req),
        .out_mon (out_res),
        .pending (pending),
        .errors  (errors)
    );

    initial
        clk = 1'b0;
    always #4 clk = ~clk;

    // result side backpressure in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_res.ready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left > 0)
        begin
            out_res.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            out_res.ready <= 1'b1;
            if (!calm && $urandom_range(0, 11) == 0)
                stall_left <= $urandom_range(1, 18);
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_swept_box_collision_top: done, errors");
            $finish;
        end
    end

    // present one request and hold it until taken
    task automatic send_pair(input box_req_t r);
        in_req.valid           <= 1'b1;
        in_req.first_center_x  <= r.first_center_x;
        in_req.first_center_y  <= r.first_center_y;
        in_req.first_size_x    <= r.first_size_x;
        in_req.first_size_y    <= r.first_size_y;
        in_req.second_center_x <= r.second_center_x;
        in_req.second_center_y <= r.second_center_y;
        in_req.second_size_x   <= r.second_size_x;
        in_req.second_size_y   <= r.second_size_y;
        in_req.first_vel_x     <= r.first_vel_x;
        in_req.first_vel_y     <= r.first_vel_y;
        in_req.second_vel_x    <= r.second_vel_x;
        in_req.second_vel_y    <= r.second_vel_y;
        do
            @(posedge clk);
        while (!in_req.ready);
    endtask

    task automatic idle_sender(input int cycles);
        in_req.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // box pair from plain integers, all in raw Q.8 units
    function automatic box_req_t make_pair(int p1x, int p1y, int s1x, int s1y,
                                           int p2x, int p2y, int s2x, int s2y,
                                           int v1x, int v1y, int v2x, int v2y);
        box_req_t r;
        r.first_center_x  = 24'(p1x);
        r.first_center_y  = 24'(p1y);
        r.first_size_x    = 23'(s1x);
        r.first_size_y    = 23'(s1y);
        r.second_center_x = 24'(p2x);
        r.second_center_y = 24'(p2y);
        r.second_size_x   = 23'(s2x);
        r.second_size_y   = 23'(s2y);
        r.first_vel_x     = 24'(v1x);
        r.first_vel_y     = 24'(v1y);
        r.second_vel_x    = 24'(v2x);
        r.second_vel_y    = 24'(v2y);
        return r;
    endfunction

    function automatic int near_val(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // mostly close pairs that can collide, some with one axis at rest,
    // the rest fully random bit patterns
    function automatic box_req_t random_pair();
        box_req_t     r;
        int           mode;
        int           span;
        logic [287:0] raw;
        mode = $urandom_range(0, 9);
        span = ($urandom_range(0, 3) == 0) ? 200000 : 4096;
        if (mode < 2)
        begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom};
            r   = raw[$bits(box_req_t)-1:0];
        end
        else
        begin
            r = make_pair(near_val(span), near_val(span),
                          $urandom_range(0, span), $urandom_range(0, span),
                          near_val(span), near_val(span),
                          $urandom_range(0, span), $urandom_range(0, span),
                          near_val(2 * span), near_val(2 * span),
                          near_val(2 * span), near_val(2 * span));
            if (mode == 8)
                r.second_vel_x = r.first_vel_x;
            if (mode == 9)
                r.second_vel_y = r.first_vel_y;
        end
        return r;
    endfunction

    box_req_t directed_pairs[$];

    initial
    begin
        box_req_t r;
        int       idle_len;
        rst_n        <= 1'b0;
        calm         <= 1'b0;
        in_req.valid <= 1'b0;
        r = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_fields_idle: begin
            in_req.first_center_x  <= '0;
            in_req.first_center_y  <= '0;
            in_req.first_size_x    <= '0;
            in_req.first_size_y    <= '0;
            in_req.second_center_x <= '0;
            in_req.second_center_y <= '0;
            in_req.second_size_x   <= '0;
            in_req.second_size_y   <= '0;
            in_req.first_vel_x     <= '0;
            in_req.first_vel_y     <= '0;
            in_req.second_vel_x    <= '0;
            in_req.second_vel_y    <= '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all zero: static, touching only, no hit
        directed_pairs.push_back(r);
        // static overlap on both axes
        directed_pairs.push_back(make_pair(0, 0, 512, 512, 100, 100, 512, 512, 0, 0, 0, 0));
        // static, edges just touching on x
        directed_pairs.push_back(make_pair(0, 0, 512, 512, 512, 0, 512, 512, 0, 0, 0, 0));
        // approaching from the left: left face
        directed_pairs.push_back(make_pair(-2048, 0, 256, 256, 0, 0, 256, 256, 2560, 0, 0, 0));
        // approaching from the right: right face
        directed_pairs.push_back(make_pair(2048, 0, 256, 256, 0, 0, 256, 256, 0, 0, 2560, 0));
        // approaching from below: bottom face
        directed_pairs.push_back(make_pair(0, -2048, 256, 256, 0, 0, 256, 256, 0, 0, 0, -2560));
        // approaching from above: top face
        directed_pairs.push_back(make_pair(0, 2048, 256, 256, 0, 0, 256, 256, 0, -2560, 0, 0));
        // diagonal approach with equal entry times on both axes
        directed_pairs.push_back(make_pair(-1024, -1024, 256, 256, 0, 0, 256, 256,
                                           1024, 1024, 0, 0));
        // already overlapping while moving: entry time before the step
        directed_pairs.push_back(make_pair(0, 0, 4096, 4096, 10, 10, 4096, 4096, 1, 1, 0, 0));
        // too slow to arrive within the step
        directed_pairs.push_back(make_pair(-8192, 0, 256, 256, 0, 0, 256, 256, 100, 0, 0, 0));
        // moving apart
        directed_pairs.push_back(make_pair(-2048, 0, 256, 256, 0, 0, 256, 256, -3000, 0, 0, 0));
        // arrives exactly at the end of the step
        directed_pairs.push_back(make_pair(-1256, 0, 512, 512, 0, 0, 512, 512, 744, 0, 0, 0));
        // field extremes
        directed_pairs.push_back(make_pair(8388607, 8388607, 8388607, 8388607,
                                           -8388608, -8388608, 8388607, 8388607,
                                           -8388608, -8388608, 8388607, 8388607));
        directed_pairs.push_back(make_pair(-8388608, -8388608, 8388607, 8388607,
                                           8388607, 8388607, 8388607, 8388607,
                                           8388607, 8388607, -8388608, -8388608));
        directed_pairs.push_back(make_pair(-8388608, 8388607, 0, 0, 8388607, -8388608,
                                           0, 0, -8388608, 8388607, -8388608, 8388607));
        directed_pairs.push_back(make_pair(-1, -1, 8388607, 1, 0, 0, 1, 8388607,
                                           1, -1, -1, 1));
        directed_pairs.push_back(make_pair(0, 0, 1, 1, 1, 1, 1, 1, 8388607, 8388607,
                                           -8388608, -8388608));

        foreach (directed_pairs[i])
        begin
            send_pair(directed_pairs[i]);
            if ($urandom_range(0, 2) == 0)
                idle_sender($urandom_range(1, 18));
        end

        // hold off until every directed result is back
        in_req.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            if (i == RANDOM_PAIRS - CALM_TAIL)
                calm <= 1'b1;
            send_pair(random_pair());
            // every third block of a hundred runs without gaps
            if (i < RANDOM_PAIRS - CALM_TAIL && (i / 100) % 3 != 2 &&
                $urandom_range(0, 7) == 0)
            begin
                idle_len = $urandom_range(1, 18);
                idle_sender(idle_len);
            end
        end
        in_req.valid <= 1'b0;

        // drain, then allow for the pipeline latency
        do
            @(posedge clk);
        while (pending != 0);
        repeat (40) @(posedge clk);

        if (errors == 0)
            $display("tb_swept_box_collision_top: done, clean");
        else
            $display("tb_swept_box_collision_top: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sba_pkg.sv
design/sba_ifs.sv
design/sba_front.sv
design/sba_div.sv
design/sba_decide.sv
design/swept_box_collision_top.sv
tb/sv/sba_contact_checker.sv
tb/sv/tb_swept_box_collision_top.sv
